@@ sv/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/msod_pkg.sv @@
`default_nettype none

package msod_pkg;

  localparam int WINDOW    = 8;
  localparam int MOTORS    = 4;
  localparam int FIELD_LANES = 4;
  localparam int NUM_LANES = (MOTORS < FIELD_LANES) ? MOTORS : FIELD_LANES;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 15;
  localparam int THR_W    = 15;
  localparam int SUM_W    = $clog2(WINDOW * 32767 + 1);

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 16;
  localparam int MASK_LSB   = 2 * FIELD_LANES * SAMPLE_W;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  localparam logic REG_SPEED_THR   = 1'b0;
  localparam logic REG_CURRENT_THR = 1'b1;

  localparam logic [THR_W-1:0] SPEED_THR_RST   = 15'd0;
  localparam logic [THR_W-1:0] CURRENT_THR_RST = 15'd32767;

  typedef struct packed {
    logic                   all_okay;
    logic [FIELD_LANES-1:0] stalled_now;
    logic [FIELD_LANES-1:0] overload_flags;
  } res_t;

  function automatic logic [MAG_W-1:0] abs_sat(input logic [SAMPLE_W-1:0] x);
    logic [SAMPLE_W-1:0] neg;
    neg = SAMPLE_W'(~x + 1'b1);
    if (!x[SAMPLE_W-1]) begin
      return x[MAG_W-1:0];
    end else if (neg[SAMPLE_W-1]) begin
      return {MAG_W{1'b1}};
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ sv/msod_lane.sv @@
`default_nettype none

module msod_lane
  import msod_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                sample_i,
  input  wire logic [SAMPLE_W-1:0] speed_i,
  input  wire logic [SAMPLE_W-1:0] current_i,
  input  wire logic [THR_W-1:0]    speed_thr_i,
  input  wire logic [THR_W-1:0]    current_thr_i,
  output logic                     stalled_o
);

  logic [WINDOW-1:0][MAG_W-1:0] spd_hist_q, spd_hist_d;
  logic [WINDOW-1:0][MAG_W-1:0] cur_hist_q, cur_hist_d;
  logic [SUM_W-1:0] spd_sum_q, spd_sum_d;
  logic [SUM_W-1:0] cur_sum_q, cur_sum_d;
  logic [MAG_W-1:0] spd_mag, cur_mag;
  logic [SUM_W-1:0] spd_limit, cur_limit;

  always_comb begin
    spd_mag    = abs_sat(speed_i);
    cur_mag    = abs_sat(current_i);
    spd_hist_d = {spd_hist_q[WINDOW-2:0], spd_mag};
    cur_hist_d = {cur_hist_q[WINDOW-2:0], cur_mag};
    spd_sum_d  = spd_sum_q - SUM_W'(spd_hist_q[WINDOW-1]) + SUM_W'(spd_mag);
    cur_sum_d  = cur_sum_q - SUM_W'(cur_hist_q[WINDOW-1]) + SUM_W'(cur_mag);
    spd_limit  = SUM_W'(SUM_W'(speed_thr_i) * SUM_W'(WINDOW));
    cur_limit  = SUM_W'(SUM_W'(current_thr_i) * SUM_W'(WINDOW));
    stalled_o  = (spd_sum_d < spd_limit) && (cur_sum_d > cur_limit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_hist_q <= '0;
      cur_hist_q <= '0;
      spd_sum_q  <= '0;
      cur_sum_q  <= '0;
    end else if (sample_i) begin
      spd_hist_q <= spd_hist_d;
      cur_hist_q <= cur_hist_d;
      spd_sum_q  <= spd_sum_d;
      cur_sum_q  <= cur_sum_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/msod_merge.sv @@
`default_nettype none

`include "assert_macros.svh"

module msod_merge
  import msod_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   mode_i,
  input  wire logic [FIELD_LANES-1:0] clear_mask_i,
  input  wire logic [FIELD_LANES-1:0] stalled_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output res_t                        out_o
);

  logic                   flags_en;
  logic [FIELD_LANES-1:0] flags_q, flags_d;
  res_t                   res;
  res_t                   out_q, out_d, skid_q, skid_d;
  logic                   out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic                   push, pop;

  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign flags_en    = push;

  always_comb begin
    res = '0;
    if (mode_i == MODE_CLEAR) begin
      flags_d = flags_q & ~clear_mask_i;
    end else begin
      flags_d         = flags_q | stalled_i;
      res.stalled_now = stalled_i;
    end
    res.overload_flags = flags_d;
    res.all_okay       = (flags_d == '0);
  end

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (pop || !out_valid_q) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (flags_en) begin
        flags_q <= flags_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `ASSERT_IMPLIES(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `ASSERT_IMPLIES(a_okay_matches_flags, clk_i, rst_ni, out_valid_q,
                  out_q.all_okay == (out_q.overload_flags == '0))
  `ASSERT_IMPLIES(a_stalled_sets_flags, clk_i, rst_ni, out_valid_q,
                  (out_q.stalled_now & ~out_q.overload_flags) == '0)
  `ASSERT_NEXT(a_clear_drops_bits, clk_i, rst_ni, push && (mode_i == MODE_CLEAR),
               (flags_q & $past(clear_mask_i)) == '0)

endmodule

`default_nettype wire

@@ sv/motor_stall_overload_detector.sv @@
// Channel   Dir  Handshake                Payload
// s_axis    in   s_axis_tvalid/tready     tdata: samples + clear mask, tuser: mode
// m_axis    out  m_axis_tvalid/tready     tdata: flags, stalled, all-okay
// cfg       in   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i (thresholds)
//
// One item per cycle while s_axis_tready is high; each result is registered.
// Each lane registers its running sums per sample; the flag merge is same-cycle.
// A two-entry output buffer keeps s_axis_tready high while one result waits.
// Reset clears windows, sums, flags and thresholds to their initial values.
`default_nettype none

module motor_stall_overload_detector
  import msod_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // speed_0..3, current_0..3 (16b each), clear_mask (4b), zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // overload_flags (4b), stalled_now (4b), all_okay (1b), zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic                  cfg_index_i,
  input  wire logic [THR_W-1:0]      cfg_data_i
);

  logic [THR_W-1:0]       spd_thr_q, cur_thr_q;
  logic [FIELD_LANES-1:0] stalled;
  logic                   sample;
  res_t                   res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_thr_q <= SPEED_THR_RST;
      cur_thr_q <= CURRENT_THR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SPEED_THR:   spd_thr_q <= cfg_data_i;
        REG_CURRENT_THR: cur_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sample = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_SAMPLE);

  for (genvar i = 0; i < FIELD_LANES; i++) begin : g_lane
    if (i < NUM_LANES) begin : g_on
      msod_lane u_lane (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .sample_i      (sample),
        .speed_i       (s_axis_tdata[i*SAMPLE_W +: SAMPLE_W]),
        .current_i     (s_axis_tdata[(FIELD_LANES+i)*SAMPLE_W +: SAMPLE_W]),
        .speed_thr_i   (spd_thr_q),
        .current_thr_i (cur_thr_q),
        .stalled_o     (stalled[i])
      );
    end else begin : g_off
      assign stalled[i] = 1'b0;
    end
  end

  msod_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .mode_i       (s_axis_tuser),
    .clear_mask_i (s_axis_tdata[MASK_LSB +: FIELD_LANES]),
    .stalled_i    (stalled),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  assign m_axis_tdata = OUT_DATA_W'({res.all_okay, res.stalled_now, res.overload_flags});

endmodule

`default_nettype wire
